### hw/rtl/pbre_pkg.sv
// ----------------------------------------------------------------------------
// pbre_pkg
// Shared types and constants of the PackBits row encoder: packet and
// command descriptors passed from the front end to the back end.
// ----------------------------------------------------------------------------
package pbre_pkg;

  localparam int RESULT_CAP = 18;
  localparam int RCNT_W     = 5;
  localparam int CMD_DEPTH  = 4;
  localparam int LEN_W      = 8;
  localparam int WORD_BYTES = 8;

  typedef enum logic {
    PKT_LITERAL = 1'b0,
    PKT_RUN     = 1'b1
  } pkt_kind_t;

  typedef struct packed {
    pkt_kind_t        kind;
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [7:0]       header;
    logic [7:0]       value;
  } pkt_t;

  typedef struct packed {
    logic has_a;
    logic has_b;
    pkt_t a;
    pkt_t b;
  } cmd_t;

endpackage

### hw/rtl/pbre_store.sv
// ----------------------------------------------------------------------------
// pbre_store
// Two-bank literal byte store. Bytes are written one lane at a time;
// reads return one full row of output width, registered.
// ----------------------------------------------------------------------------
module pbre_store #(
  parameter int MAX_PACKET = 128,
  parameter int OUT_BYTES  = 8,
  localparam int ROWS   = (MAX_PACKET + OUT_BYTES - 1) / OUT_BYTES,
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int LANE_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1,
  localparam int ADDR_W = ROW_W + 1
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  logic [LANE_W-1:0]      wr_lane,
  input  logic [7:0]             wr_data,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  output logic [OUT_BYTES*8-1:0] rd_data
);

  logic [OUT_BYTES*8-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/pbre_cmd_queue.sv
// ----------------------------------------------------------------------------
// pbre_cmd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pbre_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  pbre_pkg::cmd_t din,
  input  logic           pop,
  output logic           empty,
  output pbre_pkg::cmd_t dout
);

  import pbre_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);

  cmd_t             slots [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PTR_W + 1)'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign dout    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

### hw/rtl/pbre_front.sv
// ----------------------------------------------------------------------------
// pbre_front
// Input stage and row tracker: buffers literal bytes, detects runs and
// packet boundaries, and queues packet commands for the back end.
// ----------------------------------------------------------------------------
module pbre_front #(
  parameter int MAX_PACKET = 128,
  parameter int MIN_RUN    = 3,
  parameter int OUT_BYTES  = 8,
  localparam int ROWS   = (MAX_PACKET + OUT_BYTES - 1) / OUT_BYTES,
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int LANE_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1,
  localparam int ADDR_W = ROW_W + 1,
  localparam int FW     = $clog2(2 * MAX_PACKET + 2),
  localparam int RS_W   = $clog2(MAX_PACKET)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               row_end,
  output logic               cmd_push,
  input  logic               cmd_full,
  output pbre_pkg::cmd_t     cmd,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic [LANE_W-1:0]  wr_lane,
  output logic [7:0]         wr_data,
  input  logic [1:0]         busy_clr
);

  import pbre_pkg::*;

  function automatic pkt_t make_lit(logic bank_sel, logic [7:0] count);
    pkt_t p;
    p.kind   = PKT_LITERAL;
    p.bank   = bank_sel;
    p.len    = LEN_W'({1'b0, count} + 9'd1);
    p.header = count - 8'd1;
    p.value  = 8'h00;
    return p;
  endfunction

  function automatic pkt_t make_run(logic [7:0] value, logic [7:0] count);
    pkt_t p;
    p.kind   = PKT_RUN;
    p.bank   = 1'b0;
    p.len    = LEN_W'(2);
    p.header = 8'(9'd257 - {1'b0, count});
    p.value  = value;
    return p;
  endfunction

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              hold_end;
  logic [FW-1:0]     fill_count;
  logic [RS_W-1:0]   run_start;
  logic              in_run_mode;
  logic [7:0]        prev_byte;
  logic              row_open;
  logic              bank;
  logic [ROW_W-1:0]  pos_row;
  logic [LANE_W-1:0] pos_lane;
  logic [1:0]        busy;

  logic [FW-1:0]     fill_count_next;
  logic [RS_W-1:0]   run_start_next;
  logic              in_run_mode_next;
  logic              bank_next;
  logic [ROW_W-1:0]  pos_row_next;
  logic [LANE_W-1:0] pos_lane_next;
  logic [1:0]        busy_next;

  logic              fire;
  logic              span;
  logic              dump_wr;
  logic              a_valid;
  logic              b_valid;
  pkt_t              a_pkt;
  pkt_t              b_pkt;
  logic [FW-1:0]     fill_inc;
  logic [FW-1:0]     run_len;
  logic              lane_last;

  always_comb begin
    fill_inc         = fill_count + 1'b1;
    run_len          = fill_inc - FW'(run_start);
    lane_last        = (pos_lane == LANE_W'(OUT_BYTES - 1));
    span             = 1'b0;
    dump_wr          = 1'b0;
    a_valid          = 1'b0;
    a_pkt            = '0;
    fill_count_next  = fill_count;
    run_start_next   = run_start;
    in_run_mode_next = in_run_mode;
    bank_next        = bank;
    pos_row_next     = pos_row;
    pos_lane_next    = pos_lane;

    if (!row_open) begin
      span = 1'b1;
    end else if (!in_run_mode) begin
      fill_count_next = fill_inc;
      dump_wr         = (fill_count < FW'(MAX_PACKET));
      pos_lane_next   = lane_last ? '0 : pos_lane + 1'b1;
      pos_row_next    = lane_last ? pos_row + 1'b1 : pos_row;
      if (fill_inc > FW'(MAX_PACKET)) begin
        a_valid = 1'b1;
        a_pkt   = make_lit(bank, 8'(MAX_PACKET));
        span    = 1'b1;
      end else if (hold_byte == prev_byte) begin
        if (run_len >= FW'(MIN_RUN)) begin
          if (run_start != '0) begin
            a_valid = 1'b1;
            a_pkt   = make_lit(bank, 8'(run_start));
          end
          in_run_mode_next = 1'b1;
        end else if (run_start == '0) begin
          in_run_mode_next = 1'b1;
        end
      end else begin
        run_start_next = RS_W'(fill_count);
      end
    end else begin
      fill_count_next = fill_inc;
      if (hold_byte != prev_byte || run_len > FW'(MAX_PACKET)) begin
        a_valid = 1'b1;
        a_pkt   = make_run(prev_byte, 8'(fill_count - FW'(run_start)));
        span    = 1'b1;
      end
    end

    if (span) begin
      bank_next        = !bank;
      fill_count_next  = FW'(1);
      run_start_next   = '0;
      in_run_mode_next = 1'b0;
      pos_row_next     = (OUT_BYTES == 1) ? ROW_W'(1) : '0;
      pos_lane_next    = (OUT_BYTES == 1) ? '0 : LANE_W'(1);
    end

    b_valid = hold_end;
    if (in_run_mode_next) begin
      b_pkt = make_run(hold_byte, 8'(fill_count_next - FW'(run_start_next)));
    end else begin
      b_pkt = make_lit(bank_next, 8'(fill_count_next));
    end
  end

  assign fire     = hold_valid && !((a_valid || b_valid) && cmd_full)
                    && !(span && busy[!bank]);
  assign full     = hold_valid && !fire;
  assign cmd_push = fire && (a_valid || b_valid);
  assign cmd      = '{has_a: a_valid, has_b: b_valid, a: a_pkt, b: b_pkt};

  assign wr_en   = fire && (span || dump_wr);
  assign wr_addr = span ? {!bank, ROW_W'(0)} : {bank, pos_row};
  assign wr_lane = span ? '0 : pos_lane;
  assign wr_data = hold_byte;

  always_comb begin
    busy_next = busy & ~busy_clr;
    if (fire && a_valid && a_pkt.kind == PKT_LITERAL) begin
      busy_next[a_pkt.bank] = 1'b1;
    end
    if (fire && b_valid && b_pkt.kind == PKT_LITERAL) begin
      busy_next[b_pkt.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid  <= 1'b0;
      fill_count  <= '0;
      run_start   <= '0;
      in_run_mode <= 1'b0;
      prev_byte   <= 8'h00;
      row_open    <= 1'b0;
      bank        <= 1'b0;
      pos_row     <= '0;
      pos_lane    <= '0;
      busy        <= 2'b00;
    end else begin
      busy <= busy_next;
      if (push && !full) begin
        hold_valid <= 1'b1;
      end else if (fire) begin
        hold_valid <= 1'b0;
      end
      if (fire) begin
        fill_count  <= fill_count_next;
        run_start   <= run_start_next;
        in_run_mode <= in_run_mode_next;
        prev_byte   <= hold_byte;
        row_open    <= !hold_end;
        bank        <= bank_next;
        pos_row     <= pos_row_next;
        pos_lane    <= pos_lane_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      hold_byte <= data_byte;
      hold_end  <= row_end;
    end
  end

endmodule

### hw/rtl/pbre_back.sv
// ----------------------------------------------------------------------------
// pbre_back
// Packet sequencer and output register: walks each queued command, reads
// literal rows from the store and emits one chunk of up to OUT_BYTES bytes
// per transaction.
// ----------------------------------------------------------------------------
module pbre_back #(
  parameter int MAX_PACKET = 128,
  parameter int OUT_BYTES  = 8,
  localparam int ROWS   = (MAX_PACKET + OUT_BYTES - 1) / OUT_BYTES,
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int ADDR_W = ROW_W + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  pbre_pkg::cmd_t         cmd,
  output logic [1:0]             busy_clr,
  output logic                   rd_en,
  output logic [ADDR_W-1:0]      rd_addr,
  input  logic [OUT_BYTES*8-1:0] rd_data,
  output logic                   empty,
  input  logic                   pop,
  output logic [63:0]            packed_bytes,
  output logic [3:0]             byte_count,
  output logic                   last
);

  import pbre_pkg::*;

  logic              pkt_sel;
  logic              first;
  logic [LEN_W-1:0]  rem;
  logic [ROW_W-1:0]  row;
  logic [RCNT_W-1:0] rcount;

  logic              out_valid;
  pkt_kind_t         o_kind;
  logic              o_first;
  logic [7:0]        o_header;
  logic [7:0]        o_value;
  logic [3:0]        o_take;
  logic              o_last;
  logic [7:0]        carry;

  pkt_t              cur;
  logic              last_pkt;
  logic [LEN_W-1:0]  rem_cur;
  logic [ROW_W-1:0]  row_cur;
  logic              pkt_done;
  logic              cmd_done;
  logic [3:0]        take;
  logic              issue;
  logic [7:0]        lane_byte [WORD_BYTES];

  always_comb begin
    cur      = (!pkt_sel && cmd.has_a) ? cmd.a : cmd.b;
    last_pkt = pkt_sel || !cmd.has_a || !cmd.has_b;
    rem_cur  = first ? cur.len : rem;
    row_cur  = first ? '0 : row;
    pkt_done = (rem_cur <= LEN_W'(OUT_BYTES));
    take     = pkt_done ? 4'(rem_cur) : 4'(OUT_BYTES);
    cmd_done = (pkt_done && last_pkt) || (rcount == RCNT_W'(RESULT_CAP - 1));
    issue    = !q_empty && (!out_valid || pop);
    q_pop    = issue && cmd_done;
    rd_en    = issue;
    rd_addr  = {cur.bank, row_cur};
    busy_clr = 2'b00;
    if (q_pop && cmd.has_a && cmd.a.kind == PKT_LITERAL) begin
      busy_clr[cmd.a.bank] = 1'b1;
    end
    if (q_pop && cmd.has_b && cmd.b.kind == PKT_LITERAL) begin
      busy_clr[cmd.b.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_sel   <= 1'b0;
      first     <= 1'b1;
      rcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (issue) begin
        if (cmd_done) begin
          pkt_sel <= 1'b0;
          first   <= 1'b1;
          rcount  <= '0;
        end else if (pkt_done) begin
          pkt_sel <= 1'b1;
          first   <= 1'b1;
          rcount  <= rcount + 1'b1;
        end else begin
          first   <= 1'b0;
          rcount  <= rcount + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rem      <= rem_cur - LEN_W'(OUT_BYTES);
      row      <= row_cur + 1'b1;
      o_kind   <= cur.kind;
      o_first  <= first;
      o_header <= cur.header;
      o_value  <= cur.value;
      o_take   <= take;
      o_last   <= cmd_done;
      carry    <= rd_data[OUT_BYTES*8-1 -: 8];
    end
  end

  for (genvar j = 0; j < WORD_BYTES; j++) begin : g_lane
    if (j == 0) begin : g_head
      assign lane_byte[j] = o_first ? o_header :
                            (o_kind == PKT_LITERAL) ? carry : o_value;
    end else if (j < OUT_BYTES) begin : g_body
      assign lane_byte[j] = (o_kind == PKT_LITERAL) ? rd_data[(j-1)*8 +: 8] : o_value;
    end else begin : g_unused
      assign lane_byte[j] = 8'h00;
    end
    assign packed_bytes[j*8 +: 8] = (4'(j) < o_take) ? lane_byte[j] : 8'h00;
  end

  assign empty      = !out_valid;
  assign byte_count = o_take;
  assign last       = o_last;

endmodule

### hw/rtl/packbits_row_encoder_top.sv
// ----------------------------------------------------------------------------
// packbits_row_encoder_top
// PackBits row encoder: one raw byte per input transaction, packed output
// chunks of up to OUT_BYTES encoded bytes per result transaction.
//
// Input side is a queue write port: push a byte with row_end marking the
// last byte of a row while full is low. Result side is a queue read port:
// while empty is low the oldest chunk sits on packed_bytes/byte_count/last;
// pop takes it. last marks the final chunk caused by one input byte.
// The front end takes one byte per cycle while full is low. The back end
// reads one literal row per chunk through the single store read port; a
// byte passes the front end hold register and the command queue before its
// first chunk reaches the output register. Literal bytes sit in two store
// banks, so the front end keeps filling one while the other drains; it holds
// full only when it must open a new span in a bank still being read, or when
// the 4-entry command queue is full. A stalled receiver backs up through the
// queue to full. Reset clears all control state; the store needs no clearing
// pass.
// ----------------------------------------------------------------------------
module packbits_row_encoder_top #(
  parameter int MAX_PACKET = 128,
  parameter int MIN_RUN    = 3,
  parameter int OUT_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        row_end,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] packed_bytes,
  output logic [3:0]  byte_count,
  output logic        last
);

  import pbre_pkg::*;

  localparam int ROWS   = (MAX_PACKET + OUT_BYTES - 1) / OUT_BYTES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
  localparam int ADDR_W = ROW_W + 1;

  logic                   cmd_push;
  logic                   cmd_full;
  cmd_t                   cmd_in;
  logic                   cmd_pop;
  logic                   cmd_empty;
  cmd_t                   cmd_head;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [LANE_W-1:0]      wr_lane;
  logic [7:0]             wr_data;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [OUT_BYTES*8-1:0] rd_data;
  logic [1:0]             busy_clr;

  pbre_front #(
    .MAX_PACKET (MAX_PACKET),
    .MIN_RUN    (MIN_RUN),
    .OUT_BYTES  (OUT_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .row_end   (row_end),
    .cmd_push  (cmd_push),
    .cmd_full  (cmd_full),
    .cmd       (cmd_in),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_lane   (wr_lane),
    .wr_data   (wr_data),
    .busy_clr  (busy_clr)
  );

  pbre_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .full  (cmd_full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_head)
  );

  pbre_store #(
    .MAX_PACKET (MAX_PACKET),
    .OUT_BYTES  (OUT_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_lane (wr_lane),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pbre_back #(
    .MAX_PACKET (MAX_PACKET),
    .OUT_BYTES  (OUT_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (cmd_empty),
    .q_pop        (cmd_pop),
    .cmd          (cmd_head),
    .busy_clr     (busy_clr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .empty        (empty),
    .pop          (pop),
    .packed_bytes (packed_bytes),
    .byte_count   (byte_count),
    .last         (last)
  );

endmodule
